// ===== sv/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmr_pkg: shared types and constants for the move-to-rectangle clipper
// Configuration register indexes, wall reset magnitude and the pipeline
// control bundle passed between the core and the divider.
// ----------------------------------------------------------------------------
package cmr_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MIN_X = 2'd0,
		REG_MIN_Y = 2'd1,
		REG_MAX_X = 2'd2,
		REG_MAX_Y = 2'd3
	} cfg_reg_t;

	// Wall positions after reset are plus and minus this value
	localparam int WALL_RESET_MAG = 16000;

	// Wall numbers, in test order
	localparam int WALL_LEFT  = 0;
	localparam int WALL_RIGHT = 1;
	localparam int WALL_LOW   = 2;
	localparam int WALL_HIGH  = 3;
	localparam int NUM_WALLS  = 4;

	// Pipeline control handed to a sub-pipeline
	typedef struct packed {
		logic advance;
		logic valid;
	} pipe_ctl_t;

endpackage

// ===== sv/cmr_div.sv =====
// ----------------------------------------------------------------------------
// cmr_div: pipelined fraction divider
// Restoring division of a numerator not above the denominator, one quotient
// bit per stage, giving floor(num * 2^(QBITS-1) / den). Side data follows.
// ----------------------------------------------------------------------------
module cmr_div #(
	parameter int WIDTH  = 17,
	parameter int QBITS  = 17,
	parameter int SIDE_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmr_pkg::pipe_ctl_t    ctl,
	input  logic [WIDTH-1:0]      num,
	input  logic [WIDTH-1:0]      den,
	input  logic [SIDE_W-1:0]     side,
	output logic                  out_vld,
	output logic [QBITS-1:0]      quot,
	output logic [SIDE_W-1:0]     side_out
);

	logic              vld_q  [QBITS];
	logic [WIDTH:0]    rem_q  [QBITS];
	logic [WIDTH-1:0]  den_q  [QBITS];
	logic [QBITS-1:0]  quo_q  [QBITS];
	logic [SIDE_W-1:0] side_q [QBITS];

	for (genvar i = 0; i < QBITS; i++) begin : g_stage
		logic [WIDTH:0]    r_in;
		logic [WIDTH-1:0]  d_in;
		logic [QBITS-1:0]  q_in;
		logic [SIDE_W-1:0] s_in;
		logic              v_in;
		logic              q_bit;

		// Take the partial remainder from the previous stage, doubled; the first stage takes the numerator
		always_comb begin
			if (i == 0) begin
				r_in = {1'b0, num};
				d_in = den;
				q_in = '0;
				s_in = side;
				v_in = ctl.valid;
			end else begin
				r_in = {rem_q[(i > 0) ? i-1 : 0][WIDTH-1:0], 1'b0};
				d_in = den_q[(i > 0) ? i-1 : 0];
				q_in = quo_q[(i > 0) ? i-1 : 0];
				s_in = side_q[(i > 0) ? i-1 : 0];
				v_in = vld_q[(i > 0) ? i-1 : 0];
			end
			q_bit = (r_in >= {1'b0, d_in});
		end

		// Advance valid bits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (ctl.advance) begin
				vld_q[i] <= v_in;
			end
		end

		// Subtract where the divisor fits and shift in the quotient bit
		always_ff @(posedge clk) begin
			if (ctl.advance) begin
				rem_q[i]  <= q_bit ? (r_in - {1'b0, d_in}) : r_in;
				den_q[i]  <= d_in;
				quo_q[i]  <= {q_in[QBITS-2:0], q_bit};
				side_q[i] <= s_in;
			end
		end
	end

	assign out_vld  = vld_q[QBITS-1];
	assign quot     = quo_q[QBITS-1];
	assign side_out = side_q[QBITS-1];

endmodule

// ===== sv/clip_move_to_rectangle_core.sv =====
// ----------------------------------------------------------------------------
// clip_move_to_rectangle_core: clip a move to a configured rectangle
// The wall-crossing fraction t comes from a one-bit-per-stage divider.
// Throughput is one item per cycle; a stall at the output holds every stage.
// Reset clears all valid bits and loads the walls to -16000 and 16000.
// ----------------------------------------------------------------------------
module clip_move_to_rectangle_core #(
	parameter int COORD_WIDTH     = 16,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// Configuration
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [COORD_WIDTH-1:0] cfg_wdata,
	// Input items
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// start_x, start_y, target_x, target_y
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// Result items
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// result_x, result_y, clipped, zero fill
	output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);

	localparam int CW    = COORD_WIDTH;
	localparam int W     = CW + 1;
	localparam int P     = 2 * W;
	localparam int S     = P + 1;
	localparam int QB    = PARAM_FRAC_BITS + 1;
	localparam int OUT_W = ((2*CW+1+7)/8)*8;
	localparam int SIDE_W = 4*CW + 2*W + 1;
	localparam int MW    = W + QB + 1;

	// ---------------- configuration registers ----------------
	logic signed [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= CW'(-cmr_pkg::WALL_RESET_MAG);
			min_y_q <= CW'(-cmr_pkg::WALL_RESET_MAG);
			max_x_q <= CW'(cmr_pkg::WALL_RESET_MAG);
			max_y_q <= CW'(cmr_pkg::WALL_RESET_MAG);
		end else if (cfg_we) begin
			case (cmr_pkg::cfg_reg_t'(cfg_addr))
				cmr_pkg::REG_MIN_X: min_x_q <= cfg_wdata;
				cmr_pkg::REG_MIN_Y: min_y_q <= cfg_wdata;
				cmr_pkg::REG_MAX_X: max_x_q <= cfg_wdata;
				cmr_pkg::REG_MAX_Y: max_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic out_vld_q;
	logic advance;

	assign advance       = !out_vld_q || m_axis_tready;
	assign s_axis_tready = advance;

	logic signed [CW-1:0] ax, ay, bx, by;
	assign ax = s_axis_tdata[CW-1:0];
	assign ay = s_axis_tdata[2*CW-1:CW];
	assign bx = s_axis_tdata[3*CW-1:2*CW];
	assign by = s_axis_tdata[4*CW-1:3*CW];

	// ---------------- stage 1: differences and inside test ----------------
	logic                 vld_s1, inside_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [W-1:0]  dx_s1, dy_s1, hx_s1, hy_s1;
	logic signed [W-1:0]  exl_s1, exr_s1, eyl_s1, eyh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ax_s1     <= ax;
			ay_s1     <= ay;
			bx_s1     <= bx;
			by_s1     <= by;
			inside_s1 <= (bx >= min_x_q) && (by >= min_y_q) &&
			             (bx <= max_x_q) && (by <= max_y_q);
			dx_s1     <= W'(bx) - W'(ax);
			dy_s1     <= W'(by) - W'(ay);
			hx_s1     <= W'(max_x_q) - W'(min_x_q);
			hy_s1     <= W'(max_y_q) - W'(min_y_q);
			exl_s1    <= W'(min_x_q) - W'(ax);
			exr_s1    <= W'(max_x_q) - W'(ax);
			eyl_s1    <= W'(min_y_q) - W'(ay);
			eyh_s1    <= W'(max_y_q) - W'(ay);
		end
	end

	// ---------------- stage 2: cross products ----------------
	logic                 vld_s2, inside_s2;
	logic signed [CW-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [W-1:0]  dx_s2, dy_s2, exl_s2, exr_s2, eyl_s2, eyh_s2;
	logic signed [P-1:0]  dxhy_s2, dyhx_s2, hyexl_s2, hyexr_s2, hxeyl_s2, hxeyh_s2;
	logic signed [P-1:0]  dxeyl_s2, dyexl_s2, dyexr_s2, dxeyh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s2 <= inside_s1;
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;
			bx_s2     <= bx_s1;
			by_s2     <= by_s1;
			dx_s2     <= dx_s1;
			dy_s2     <= dy_s1;
			exl_s2    <= exl_s1;
			exr_s2    <= exr_s1;
			eyl_s2    <= eyl_s1;
			eyh_s2    <= eyh_s1;
			dxhy_s2   <= P'(dx_s1) * P'(hy_s1);
			dyhx_s2   <= P'(dy_s1) * P'(hx_s1);
			hyexl_s2  <= P'(hy_s1) * P'(exl_s1);
			hyexr_s2  <= P'(hy_s1) * P'(exr_s1);
			hxeyl_s2  <= P'(hx_s1) * P'(eyl_s1);
			hxeyh_s2  <= P'(hx_s1) * P'(eyh_s1);
			dxeyl_s2  <= P'(dx_s1) * P'(eyl_s1);
			dyexl_s2  <= P'(dy_s1) * P'(exl_s1);
			dyexr_s2  <= P'(dy_s1) * P'(exr_s1);
			dxeyh_s2  <= P'(dx_s1) * P'(eyh_s1);
		end
	end

	// ---------------- stage 3: denominators and numerators per wall ----------------
	logic                 vld_s3, inside_s3;
	logic signed [CW-1:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic signed [W-1:0]  dx_s3, dy_s3, exl_s3, exr_s3, eyl_s3, eyh_s3;
	logic signed [S-1:0]  k_s3  [cmr_pkg::NUM_WALLS];
	logic signed [S-1:0]  tn_s3 [cmr_pkg::NUM_WALLS];
	logic signed [S-1:0]  sn_s3 [cmr_pkg::NUM_WALLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s3 <= inside_s2;
			ax_s3     <= ax_s2;
			ay_s3     <= ay_s2;
			bx_s3     <= bx_s2;
			by_s3     <= by_s2;
			dx_s3     <= dx_s2;
			dy_s3     <= dy_s2;
			exl_s3    <= exl_s2;
			exr_s3    <= exr_s2;
			eyl_s3    <= eyl_s2;
			eyh_s3    <= eyh_s2;
			k_s3[cmr_pkg::WALL_LEFT]   <= -S'(dxhy_s2);
			tn_s3[cmr_pkg::WALL_LEFT]  <= -S'(hyexl_s2);
			sn_s3[cmr_pkg::WALL_LEFT]  <= S'(dxeyl_s2) - S'(dyexl_s2);
			k_s3[cmr_pkg::WALL_RIGHT]  <= -S'(dxhy_s2);
			tn_s3[cmr_pkg::WALL_RIGHT] <= -S'(hyexr_s2);
			sn_s3[cmr_pkg::WALL_RIGHT] <= S'(dxeyl_s2) - S'(dyexr_s2);
			k_s3[cmr_pkg::WALL_LOW]    <= S'(dyhx_s2);
			tn_s3[cmr_pkg::WALL_LOW]   <= S'(hxeyl_s2);
			sn_s3[cmr_pkg::WALL_LOW]   <= S'(dxeyl_s2) - S'(dyexl_s2);
			k_s3[cmr_pkg::WALL_HIGH]   <= S'(dyhx_s2);
			tn_s3[cmr_pkg::WALL_HIGH]  <= S'(hxeyh_s2);
			sn_s3[cmr_pkg::WALL_HIGH]  <= S'(dxeyh_s2) - S'(dyexl_s2);
		end
	end

	// ---------------- stage 4: range tests and wall choice ----------------
	logic [cmr_pkg::NUM_WALLS-1:0] wall_hit;
	logic                          any_hit;
	logic signed [W-1:0]           tnr_sel, td_sel;
	logic [W-1:0]                  num_mag, den_mag;

	// Test t and s in [0,1] with the sign of k folded into the compares
	always_comb begin
		for (int w = 0; w < cmr_pkg::NUM_WALLS; w++) begin
			if (k_s3[w] > 0) begin
				wall_hit[w] = (tn_s3[w] >= 0) && (tn_s3[w] <= k_s3[w]) &&
				              (sn_s3[w] >= 0) && (sn_s3[w] <= k_s3[w]);
			end else if (k_s3[w] < 0) begin
				wall_hit[w] = (tn_s3[w] <= 0) && (tn_s3[w] >= k_s3[w]) &&
				              (sn_s3[w] <= 0) && (sn_s3[w] >= k_s3[w]);
			end else begin
				wall_hit[w] = 1'b0;
			end
		end
		any_hit = !inside_s3 && (wall_hit != '0);
		// Keep the last wall hit
		tnr_sel = exl_s3;
		td_sel  = dx_s3;
		if (wall_hit[cmr_pkg::WALL_RIGHT]) begin
			tnr_sel = exr_s3;
			td_sel  = dx_s3;
		end
		if (wall_hit[cmr_pkg::WALL_LOW]) begin
			tnr_sel = eyl_s3;
			td_sel  = dy_s3;
		end
		if (wall_hit[cmr_pkg::WALL_HIGH]) begin
			tnr_sel = eyh_s3;
			td_sel  = dy_s3;
		end
		num_mag = tnr_sel[W-1] ? W'(-tnr_sel) : W'(tnr_sel);
		den_mag = td_sel[W-1] ? W'(-td_sel) : W'(td_sel);
	end

	logic                 vld_s4, hit_s4;
	logic signed [CW-1:0] ax_s4, ay_s4, bx_s4, by_s4;
	logic signed [W-1:0]  dx_s4, dy_s4;
	logic [W-1:0]         num_s4, den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (advance) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s4 <= any_hit;
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;
			bx_s4  <= bx_s3;
			by_s4  <= by_s3;
			dx_s4  <= dx_s3;
			dy_s4  <= dy_s3;
			// Keep the divider fed with a non-zero divisor when nothing hit
			num_s4 <= any_hit ? num_mag : '0;
			den_s4 <= any_hit ? den_mag : W'(1);
		end
	end

	// ---------------- stages 5 on: fraction t ----------------
	cmr_pkg::pipe_ctl_t div_ctl;
	logic               div_vld;
	logic [QB-1:0]      tq;
	logic [SIDE_W-1:0]  div_side, div_side_out;

	assign div_ctl.advance = advance;
	assign div_ctl.valid   = vld_s4;
	assign div_side = {hit_s4, dy_s4, dx_s4, by_s4, bx_s4, ay_s4, ax_s4};

	cmr_div #(
		.WIDTH  (W),
		.QBITS  (QB),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.num      (num_s4),
		.den      (den_s4),
		.side     (div_side),
		.out_vld  (div_vld),
		.quot     (tq),
		.side_out (div_side_out)
	);

	logic signed [CW-1:0] ax_d, ay_d, bx_d, by_d;
	logic signed [W-1:0]  dx_d, dy_d;
	logic                 hit_d;

	assign ax_d  = div_side_out[CW-1:0];
	assign ay_d  = div_side_out[2*CW-1:CW];
	assign bx_d  = div_side_out[3*CW-1:2*CW];
	assign by_d  = div_side_out[4*CW-1:3*CW];
	assign dx_d  = div_side_out[4*CW+W-1:4*CW];
	assign dy_d  = div_side_out[4*CW+2*W-1:4*CW+W];
	assign hit_d = div_side_out[SIDE_W-1];

	// ---------------- multiply stage: d * t ----------------
	logic                 vld_sm, hit_sm;
	logic signed [CW-1:0] ax_sm, ay_sm, bx_sm, by_sm;
	logic signed [MW-1:0] mx_sm, my_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (advance) begin
			vld_sm <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_sm <= hit_d;
			ax_sm  <= ax_d;
			ay_sm  <= ay_d;
			bx_sm  <= bx_d;
			by_sm  <= by_d;
			mx_sm  <= MW'(dx_d) * $signed({1'b0, tq});
			my_sm  <= MW'(dy_d) * $signed({1'b0, tq});
		end
	end

	// ---------------- output register: floor shift and add ----------------
	logic signed [MW-1:0] mx_sh, my_sh;
	logic [CW-1:0]        rx_q, ry_q;
	logic                 clipped_q;

	assign mx_sh = mx_sm >>> PARAM_FRAC_BITS;
	assign my_sh = my_sm >>> PARAM_FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			clipped_q <= hit_sm;
			rx_q      <= hit_sm ? (ax_sm + mx_sh[CW-1:0]) : bx_sm;
			ry_q      <= hit_sm ? (ay_sm + my_sh[CW-1:0]) : by_sm;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_W-2*CW-1){1'b0}}, clipped_q, ry_q, rx_q};

endmodule
